>>> rtl/ietw_pkg.sv
// Shared widths and word token codes for the integer to English words block.
`timescale 1ns / 1ps

package ietw_pkg;

   // Item widths
   localparam int VAL_W   = 32;
   localparam int TOK_W   = 6;
   localparam int DIG_NUM = 10;  // decimal digits needed for a 32-bit magnitude
   localparam int CNT_W   = $clog2(VAL_W);

   // Word token codes
   localparam logic [TOK_W-1:0] TOK_TEN        = 6'd10;
   localparam logic [TOK_W-1:0] TOK_TENS_BASE  = 6'd20;
   localparam logic [TOK_W-1:0] TOK_HUNDRED    = 6'd28;
   localparam logic [TOK_W-1:0] TOK_THOUSAND   = 6'd29;
   localparam logic [TOK_W-1:0] TOK_MILLION    = 6'd30;
   localparam logic [TOK_W-1:0] TOK_MINUS      = 6'd31;
   localparam logic [TOK_W-1:0] TOK_AND        = 6'd32;
   localparam logic [TOK_W-1:0] TOK_COMMA      = 6'd33;
   localparam logic [TOK_W-1:0] TOK_HYPHEN     = 6'd34;

   // Three-digit groups of the magnitude, most significant first
   localparam logic [1:0] G_MT = 2'd0;  // thousands of millions
   localparam logic [1:0] G_MH = 2'd1;  // millions
   localparam logic [1:0] G_TH = 2'd2;  // thousands
   localparam logic [1:0] G_UN = 2'd3;  // units

endpackage

>>> rtl/integer_to_english_words.sv
// Integer to English words (British style): top level, converter and token sequencer.
//
// Spells one signed 32-bit value as a run of word tokens, one token per cycle on
// rsp_word_token with rsp_valid high, the final token flagged by rsp_last_token.
// An item is taken when start is high and busy is low. The magnitude is first turned
// into ten decimal digits by a shift-and-add-3 converter working one bit per cycle,
// the S_FIRST state then picks the first group (and issues the minus of a negative
// value), then tokens follow back to back, from 1 to 26 of them per item. busy falls
// while the last token is shown, so the next item can be taken at the edge that takes
// the last token. The receiver cannot stall: every token is shown for exactly one
// cycle. No state is kept between items.
`timescale 1ns / 1ps

module integer_to_english_words
   import ietw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic [TOK_W-1:0]        rsp_word_token,
   output logic                    rsp_last_token
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CONV,
      S_FIRST,
      S_SEP,
      S_H,
      S_HUN,
      S_AND,
      S_T,
      S_HY,
      S_U,
      S_THOU,
      S_MILL
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                grp_ff, grp_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [4*DIG_NUM-1:0]      bcd_ff, bcd_in;
   logic [VAL_W-1:0]          bin_ff, bin_in;
   logic                      neg_ff, neg_in;
   logic [TOK_W-1:0]          tok_ff, tok_in;
   logic                      vld_ff, vld_in;
   logic                      lst_ff, lst_in;

   logic [4*DIG_NUM-1:0]      bcd_adj;
   logic [3:0]                cur_h, cur_t, cur_u;
   logic [3:0]                pres, hnz, sep_ex, sep_and;
   logic                      m_nz, mh_nz, t_nz, u_nz;
   logic                      grp_done, adv, nxt_any;
   logic [2:0]                srch;
   logic [1:0]                nxt_idx;

   // Add-3 correction on every digit before the shift
   always_comb begin
      for (int i = 0; i < DIG_NUM; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Group flags from the decimal digits
   assign mh_nz = (bcd_ff[35:24] != '0);
   assign t_nz  = (bcd_ff[23:12] != '0);
   assign u_nz  = (bcd_ff[11:0]  != '0);
   assign m_nz  = (bcd_ff[39:36] != '0) || mh_nz;

   assign pres[G_MT] = (bcd_ff[39:36] != '0);
   assign pres[G_MH] = mh_nz;
   assign pres[G_TH] = t_nz;
   assign pres[G_UN] = u_nz || !(m_nz || t_nz);  // zero spells as one token

   // Hundreds digit nonzero per group
   assign hnz[G_MT] = 1'b0;
   assign hnz[G_MH] = (bcd_ff[35:32] != '0);
   assign hnz[G_TH] = (bcd_ff[23:20] != '0);
   assign hnz[G_UN] = (bcd_ff[11:8]  != '0);

   // Separator ahead of a group: "and" before a millions or units group below one hundred, else a comma
   assign sep_ex[G_MT]  = 1'b0;
   assign sep_ex[G_MH]  = pres[G_MT];
   assign sep_ex[G_TH]  = m_nz;
   assign sep_ex[G_UN]  = t_nz || m_nz;
   assign sep_and[G_MT] = 1'b0;
   assign sep_and[G_MH] = !hnz[G_MH];
   assign sep_and[G_TH] = 1'b0;
   assign sep_and[G_UN] = !hnz[G_UN];

   // Digits of the group being spelled
   always_comb begin
      case (grp_ff)
         G_MT: begin
            cur_h = '0;
            cur_t = '0;
            cur_u = bcd_ff[39:36];
         end
         G_MH: begin
            cur_h = bcd_ff[35:32];
            cur_t = bcd_ff[31:28];
            cur_u = bcd_ff[27:24];
         end
         G_TH: begin
            cur_h = bcd_ff[23:20];
            cur_t = bcd_ff[19:16];
            cur_u = bcd_ff[15:12];
         end
         default: begin
            cur_h = bcd_ff[11:8];
            cur_t = bcd_ff[7:4];
            cur_u = bcd_ff[3:0];
         end
      endcase
   end

   // Sequencer: conversion, then one token per cycle
   always_comb begin
      state_in = state_ff;
      grp_in   = grp_ff;
      cnt_in   = cnt_ff;
      bcd_in   = bcd_ff;
      bin_in   = bin_ff;
      neg_in   = neg_ff;
      tok_in   = tok_ff;
      vld_in   = 1'b0;
      grp_done = 1'b0;
      adv      = 1'b0;
      srch     = 3'd0;
      nxt_idx  = G_MT;
      nxt_any  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               neg_in = req_value[VAL_W-1];
               if (req_value[VAL_W-1]) begin
                  bin_in = ~$unsigned(req_value) + 1'b1;
               end else begin
                  bin_in = $unsigned(req_value);
               end
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            {bcd_in, bin_in} = {bcd_adj[4*DIG_NUM-2:0], bin_ff, 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VAL_W-1)) begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            if (neg_ff) begin
               vld_in = 1'b1;
               tok_in = TOK_MINUS;
            end
            adv  = 1'b1;
            srch = 3'd0;
         end
         S_SEP: begin
            vld_in   = 1'b1;
            tok_in   = sep_and[grp_ff] ? TOK_AND : TOK_COMMA;
            state_in = hnz[grp_ff] ? S_H : S_T;
         end
         S_H: begin
            vld_in   = 1'b1;
            tok_in   = {2'b00, cur_h};
            state_in = S_HUN;
         end
         S_HUN: begin
            vld_in = 1'b1;
            tok_in = TOK_HUNDRED;
            if ((cur_t != '0) || (cur_u != '0)) begin
               state_in = S_AND;
            end else begin
               grp_done = 1'b1;
            end
         end
         S_AND: begin
            vld_in   = 1'b1;
            tok_in   = TOK_AND;
            state_in = S_T;
         end
         S_T: begin
            vld_in = 1'b1;
            if (cur_t < 4'd2) begin
               // under twenty: a single word
               tok_in   = (cur_t != '0) ? TOK_TEN + {2'b00, cur_u} : {2'b00, cur_u};
               grp_done = 1'b1;
            end else begin
               tok_in = TOK_TENS_BASE + {2'b00, cur_t} - 6'd2;
               if (cur_u != '0) begin
                  state_in = S_HY;
               end else begin
                  grp_done = 1'b1;
               end
            end
         end
         S_HY: begin
            vld_in   = 1'b1;
            tok_in   = TOK_HYPHEN;
            state_in = S_U;
         end
         S_U: begin
            vld_in   = 1'b1;
            tok_in   = {2'b00, cur_u};
            grp_done = 1'b1;
         end
         S_THOU: begin
            vld_in = 1'b1;
            tok_in = TOK_THOUSAND;
            // "two thousand million" when the millions group is empty
            if ((grp_ff == G_MT) && !pres[G_MH]) begin
               state_in = S_MILL;
            end else begin
               adv  = 1'b1;
               srch = {1'b0, grp_ff} + 3'd1;
            end
         end
         S_MILL: begin
            vld_in = 1'b1;
            tok_in = TOK_MILLION;
            adv    = 1'b1;
            srch   = {1'b0, grp_ff} + 3'd1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Scale word after a group
      if (grp_done) begin
         case (grp_ff)
            G_MT, G_TH: state_in = S_THOU;
            G_MH:       state_in = S_MILL;
            default: begin
               adv  = 1'b1;
               srch = {1'b0, grp_ff} + 3'd1;
            end
         endcase
      end

      // Move on to the next group that has something to say
      if (adv) begin
         for (int g = 3; g >= 0; g--) begin
            if ((3'(g) >= srch) && pres[g]) begin
               nxt_idx = 2'(g);
               nxt_any = 1'b1;
            end
         end
         if (nxt_any) begin
            grp_in = nxt_idx;
            if (sep_ex[nxt_idx]) begin
               state_in = S_SEP;
            end else begin
               state_in = hnz[nxt_idx] ? S_H : S_T;
            end
         end else begin
            state_in = S_IDLE;
         end
      end

      lst_in = vld_in && (state_in == S_IDLE);
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
         lst_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         lst_ff   <= lst_in;
      end
      grp_ff <= grp_in;
      cnt_ff <= cnt_in;
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
      neg_ff <= neg_in;
      tok_ff <= tok_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = vld_ff;
   assign rsp_word_token = tok_ff;
   assign rsp_last_token = lst_ff;

   // Tokens only come out of the spelling states
   a_tok_src: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> ($past(state_ff) != S_IDLE) && ($past(state_ff) != S_CONV))
      else $error("token issued outside spelling");

   // No token code beyond the hyphen
   a_tok_rng: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (tok_ff <= TOK_HYPHEN))
      else $error("token code out of range");

   // Tokens of one item are contiguous
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !lst_ff) |=> vld_ff)
      else $error("gap inside a token run");

   // Last token ends the run and frees the block
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && lst_ff) |-> (state_ff == S_IDLE))
      else $error("last token while still spelling");

   // Nothing comes out during conversion
   a_conv_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONV) |-> !vld_ff)
      else $error("token during conversion");

endmodule
